FILE: hw/rtl/sbhbi_pkg.sv
// Shared types and constants for the seeded byte hash bucket index unit.
// No dependencies; the datapath, controller and top level refer to this package by scope.
package sbhbi_pkg;

	// Configuration register indexes.
	localparam logic CFG_HASH_SEED    = 1'b0;
	localparam logic CFG_BUCKET_COUNT = 1'b1;

	// Register reset values.
	localparam logic [31:0] HASH_SEED_RESET    = 32'd0;
	localparam logic [15:0] BUCKET_COUNT_RESET = 16'd709;

	// One-at-a-time mixing and finalizing shift amounts.
	localparam int MIX_SHL = 10;
	localparam int MIX_SHR = 6;
	localparam int FIN_SHL_A = 3;
	localparam int FIN_SHR = 11;
	localparam int FIN_SHL_B = 15;

	// Restoring division: one quotient bit per step.
	localparam int HASH_W    = 32;
	localparam int BUCKET_W  = 16;
	localparam int DIV_STEPS = HASH_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIN_A,
		ST_FIN_B,
		ST_DIV,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // mix the request into the running hash
		logic fin_a;     // first half of the finalizer
		logic fin_b;     // second half of the finalizer, divider start
		logic div_step;  // one restoring division step
		logic load_out;  // move hash and index into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;  // the current step is the last division step
	} dp_status_t;

endpackage

FILE: hw/rtl/sbhbi_if.sv
// Request channel interfaces: key bytes in, hash results out.
// Depends on nothing; widths follow the fixed field widths of the unit.
interface sbhbi_key_if;
	logic        valid;
	logic        ready;
	logic [7:0]  key_byte;
	logic        has_byte;
	logic        first_of_key;
	logic        last_of_key;
	logic [15:0] key_length;

	modport source (output valid, key_byte, has_byte, first_of_key, last_of_key, key_length,
		input ready);
	modport sink (input valid, key_byte, has_byte, first_of_key, last_of_key, key_length,
		output ready);
endinterface

interface sbhbi_hash_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;
	logic [15:0] bucket_index;

	modport source (output valid, hash_value, bucket_index, input ready);
	modport sink (input valid, hash_value, bucket_index, output ready);
endinterface

FILE: hw/rtl/sbhbi_datapath.sv
// Datapath: configuration registers, running hash, finalizer, serial divider
// and output payload register. Depends on sbhbi_pkg.
module sbhbi_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [31:0]             cfg_wdata,
	input  logic [7:0]              key_byte,
	input  logic                    has_byte,
	input  logic                    first_of_key,
	input  logic [15:0]             key_length,
	input  sbhbi_pkg::dp_cmd_t      cmd,
	output sbhbi_pkg::dp_status_t   status,
	output logic [31:0]             hash_value,
	output logic [15:0]             bucket_index
);

	logic [31:0] seed_q;
	logic [15:0] bcount_q;
	logic [31:0] run_q;
	logic [31:0] fin_q;
	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [sbhbi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [31:0] out_hash_q;
	logic [15:0] out_idx_q;

	logic [31:0] h_start, h_add, h_mul, h_mix, h_next;
	logic [31:0] fa_add, fa_mix, fb_add;
	logic [16:0] rem_shift, rem_sub;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= sbhbi_pkg::HASH_SEED_RESET;
			bcount_q <= sbhbi_pkg::BUCKET_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbhbi_pkg::CFG_HASH_SEED:    seed_q   <= cfg_wdata;
				sbhbi_pkg::CFG_BUCKET_COUNT: bcount_q <= cfg_wdata[15:0];
			endcase
		end
	end

	// Byte mixing: restart on the first item, then, if the request has a byte, add, shift-add, xor-shift.
	always_comb begin
		h_start = first_of_key ? seed_q + {16'd0, key_length} : run_q;
		h_add   = h_start + {24'd0, key_byte};
		h_mul   = h_add + (h_add << sbhbi_pkg::MIX_SHL);
		h_mix   = h_mul ^ (h_mul >> sbhbi_pkg::MIX_SHR);
		h_next  = has_byte ? h_mix : h_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (cmd.accept) begin
			run_q <= h_next;
		end
	end

	// Finalizer, split into the fin_a and fin_b halves.
	always_comb begin
		fa_add = run_q + (run_q << sbhbi_pkg::FIN_SHL_A);
		fa_mix = fa_add ^ (fa_add >> sbhbi_pkg::FIN_SHR);
		fb_add = fin_q + (fin_q << sbhbi_pkg::FIN_SHL_B);
	end

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		rem_shift = {rem_q, quo_q[31]};
		rem_sub   = rem_shift - {1'b0, bcount_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.fin_b) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_a) begin
			fin_q <= fa_mix;
		end else if (cmd.fin_b) begin
			fin_q <= fb_add;
		end
		if (cmd.fin_b) begin
			quo_q <= fb_add;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[30:0], 1'b0};
			rem_q <= (rem_shift >= {1'b0, bcount_q}) ? rem_sub[15:0] : rem_shift[15:0];
		end
	end

	assign status.div_last = (cnt_q == sbhbi_pkg::DIV_CNT_W'(sbhbi_pkg::DIV_STEPS - 1));

	// Output payload register; a zero bucket count gives index zero.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hash_q <= fin_q;
			out_idx_q  <= (bcount_q == 16'd0) ? 16'd0 : rem_q;
		end
	end

	assign hash_value   = out_hash_q;
	assign bucket_index = out_idx_q;

endmodule

FILE: hw/rtl/sbhbi_ctrl.sv
// Controller: sequences byte requests, finalizing, division and the result
// register handshake. Depends on sbhbi_pkg.
module sbhbi_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_last,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  sbhbi_pkg::dp_status_t  status,
	output sbhbi_pkg::dp_cmd_t     cmd
);

	sbhbi_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic in_fire;
	logic out_free;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbhbi_pkg::ST_IDLE:  if (in_fire && in_last) state_d = sbhbi_pkg::ST_FIN_A;
			sbhbi_pkg::ST_FIN_A: state_d = sbhbi_pkg::ST_FIN_B;
			sbhbi_pkg::ST_FIN_B: state_d = sbhbi_pkg::ST_DIV;
			sbhbi_pkg::ST_DIV:   if (status.div_last) state_d = sbhbi_pkg::ST_DONE;
			sbhbi_pkg::ST_DONE:  if (out_free) state_d = sbhbi_pkg::ST_IDLE;
			default:             state_d = sbhbi_pkg::ST_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			sbhbi_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			sbhbi_pkg::ST_FIN_A: cmd.fin_a    = 1'b1;
			sbhbi_pkg::ST_FIN_B: cmd.fin_b    = 1'b1;
			sbhbi_pkg::ST_DIV:   cmd.div_step = 1'b1;
			sbhbi_pkg::ST_DONE:  cmd.load_out = out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbhbi_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a result is still pending");

	// Finalizing starts only after a last request was taken.
	a_fin_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbhbi_pkg::ST_FIN_A) |-> $past(in_fire && in_last))
		else $error("finalizer started without a last request");

	// The last division step hands over to the result stage.
	a_div_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbhbi_pkg::ST_DIV && status.div_last) |=> (state_q == sbhbi_pkg::ST_DONE))
		else $error("division did not finish after its last step");

	// A loaded result is offered in the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded result not offered");

endmodule

FILE: hw/rtl/seeded_byte_hash_bucket_index_unit.sv
// Top level of the seeded byte hash bucket index unit.
// Depends on sbhbi_pkg, sbhbi_if, sbhbi_ctrl and sbhbi_datapath.
//
// Keys arrive one byte per request on key_in; a request that is not the last of
// its key is taken whenever the unit is idle, so a key streams at one byte per
// cycle. A request marked last_of_key holds the unit, and no other request is
// taken, until its result is loaded: it is taken, finalized in ST_FIN_A and
// ST_FIN_B, divided by the one-bit-per-cycle restoring divider that forms hash
// modulo bucket_count, and loaded into the result register after any wait for an
// earlier result still held there. Results leave on hash_out from that register,
// so new bytes are taken while a result waits. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; the user must write it only while the unit is
// idle; the unit itself has no guard. A bucket count of zero gives bucket index zero.
module seeded_byte_hash_bucket_index_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_wdata,
	sbhbi_key_if.sink    key_in,
	sbhbi_hash_if.source hash_out
);

	sbhbi_pkg::dp_cmd_t    cmd;
	sbhbi_pkg::dp_status_t status;

	// Controller.
	sbhbi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (key_in.valid),
		.in_last   (key_in.last_of_key),
		.in_ready  (key_in.ready),
		.out_valid (hash_out.valid),
		.out_ready (hash_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath.
	sbhbi_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.key_byte     (key_in.key_byte),
		.has_byte     (key_in.has_byte),
		.first_of_key (key_in.first_of_key),
		.key_length   (key_in.key_length),
		.cmd          (cmd),
		.status       (status),
		.hash_value   (hash_out.hash_value),
		.bucket_index (hash_out.bucket_index)
	);

endmodule
